// ===== src/tsph_pkg.sv =====
// Shared types and constants of the transport packet header parser.
`default_nettype none
package tsph_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_BAD_SYNC  = 3'd1;
	localparam status_t ST_TEI       = 3'd2;
	localparam status_t ST_BAD_ADAPT = 3'd3;
	localparam status_t ST_BAD_PTR   = 3'd4;
	localparam status_t ST_SHORT     = 3'd5;

	localparam logic [7:0] SYNC_BYTE     = 8'h47;
	localparam logic [7:0] SYNC_BYTE_INV = 8'hB8;
	localparam logic [7:0] ADAPT_LEN_MAX = 8'd183;
	localparam logic [7:0] PAYLOAD_LEN   = 8'd184;
	localparam logic [7:0] IDX_MAX       = 8'd255;
	localparam logic [15:0] PES_PREFIX   = 16'h0001;

endpackage
`default_nettype wire

// ===== src/tsph_if.sv =====
// Channel interfaces: packet bytes in, packet verdicts out.
`default_nettype none
interface tsph_byte_if;
	import tsph_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface tsph_verdict_if;
	import tsph_pkg::*;
	logic       valid;
	logic       ready;
	status_t    status;
	logic [3:0] continuity;
	logic       unit_start;
	logic       has_tail;
	logic [7:0] tail_offset;
	logic [7:0] tail_length;
	logic [7:0] new_offset;
	logic [7:0] new_length;
	logic       pes_start;

	modport source (output valid, output status, output continuity, output unit_start,
		output has_tail, output tail_offset, output tail_length, output new_offset,
		output new_length, output pes_start, input ready);
	modport sink (input valid, input status, input continuity, input unit_start,
		input has_tail, input tail_offset, input tail_length, input new_offset,
		input new_length, input pes_start, output ready);
endinterface
`default_nettype wire

// ===== src/ts_packet_header_parser.sv =====
// Transport packet header parser: byte stream in, one verdict per packet out.
//
//  channel   dir  payload                                   words
//  bytes     in   byte_in[7:0], last_byte                   one per packet byte
//  verdict   out  status, continuity, unit_start, tail/new  one per packet
//                 offsets and lengths, pes_start
//
// A byte enters the input register, then updates the header state; on the last
// byte the verdict is formed from that state in the same cycle and loaded into
// the output register. One byte per cycle unless a last byte waits on a stalled verdict.
// Reset clears all header state and both valid flags.
// A stalled verdict holds the input register only when it holds a last byte;
// other bytes keep flowing while the verdict waits.
`default_nettype none
module ts_packet_header_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	tsph_byte_if.sink      bytes,
	tsph_verdict_if.source verdict
);
	import tsph_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// header state
	logic [7:0]  byte_index_q;
	logic        sync_err_q;
	logic        tei_q, pusi_q, adapt_q;
	logic [3:0]  cc_q;
	logic [7:0]  adapt_len_q;
	logic [7:0]  pointer_q;
	logic [15:0] first_bytes_q;

	// next state
	logic        sync_err_d, tei_d, pusi_d, adapt_d;
	logic [3:0]  cc_d;
	logic [7:0]  adapt_len_d, pointer_d;
	logic [15:0] first_bytes_d;

	logic       s1_go, load_out;
	logic [8:0] idx9, n9, ppos9, cap_pos9;
	logic [7:0] datalen;

	// verdict under construction
	status_t    st;
	logic       has_tail_c, pes_c;
	logic [7:0] tail_off_c, tail_len_c, new_off_c, new_len_c;
	logic [8:0] new_off9;

	assign s1_go    = valid_s1 && (!last_s1 || !verdict.valid || verdict.ready);
	assign load_out = s1_go && last_s1;
	assign bytes.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.byte_in;
			last_s1 <= bytes.last_byte;
		end
	end

	assign idx9 = {1'b0, byte_index_q};

	// capture position from stored state; at byte 4 it can match only without an adaptation field
	assign cap_pos9 = adapt_q ? 9'd5 + {1'b0, adapt_len_q} : 9'd4;

	// header field capture for the byte in the input register
	always_comb begin
		sync_err_d    = sync_err_q;
		tei_d         = tei_q;
		pusi_d        = pusi_q;
		adapt_d       = adapt_q;
		cc_d          = cc_q;
		adapt_len_d   = adapt_len_q;
		pointer_d     = pointer_q;
		first_bytes_d = first_bytes_q;
		if (byte_index_q == 8'd0) begin
			sync_err_d = !(byte_s1 == SYNC_BYTE || byte_s1 == SYNC_BYTE_INV);
		end else if (byte_index_q == 8'd1) begin
			tei_d  = byte_s1[7];
			pusi_d = byte_s1[6];
		end else if (byte_index_q == 8'd3) begin
			adapt_d = byte_s1[5];
			cc_d    = byte_s1[3:0];
		end else if (byte_index_q >= 8'd4) begin
			if (byte_index_q == 8'd4 && adapt_q)
				adapt_len_d = byte_s1;
		end
		if (byte_index_q >= 8'd4 && pusi_q) begin
			if (idx9 == cap_pos9)
				pointer_d = byte_s1;
			else if (idx9 == cap_pos9 + 9'd1)
				first_bytes_d[15:8] = byte_s1;
			else if (idx9 == cap_pos9 + 9'd2)
				first_bytes_d[7:0] = byte_s1;
		end
	end

	// pointer byte position; adaptation length is taken as just updated
	assign ppos9   = adapt_d ? 9'd5 + {1'b0, adapt_len_d} : 9'd4;
	assign n9      = idx9 + 9'd1;
	assign datalen = adapt_d ? ADAPT_LEN_MAX - adapt_len_d : PAYLOAD_LEN;

	always_comb begin
		st         = ST_OK;
		has_tail_c = 1'b0;
		tail_off_c = 8'd0;
		tail_len_c = 8'd0;
		new_off_c  = 8'd0;
		new_len_c  = 8'd0;
		pes_c      = 1'b0;
		new_off9   = 9'd0;
		if (sync_err_d)
			st = ST_BAD_SYNC;
		else if (n9 < 9'd4)
			st = ST_SHORT;
		else if (tei_d)
			st = ST_TEI;
		else if ((adapt_d || pusi_d) && n9 < 9'd5)
			st = ST_SHORT;
		else if (adapt_d && adapt_len_d > ADAPT_LEN_MAX)
			st = ST_BAD_ADAPT;
		else if (pusi_d) begin
			if (n9 <= ppos9) begin
				st = ST_SHORT;
			end else if (pointer_d >= datalen) begin
				st = ST_BAD_PTR;
			end else begin
				has_tail_c = pointer_d != 8'd0;
				tail_off_c = has_tail_c ? 8'(ppos9 + 9'd1) : 8'd0;
				tail_len_c = pointer_d;
				new_off9   = ppos9 + 9'd1 + {1'b0, pointer_d};
				new_off_c  = new_off9[7:0];
				new_len_c  = datalen - 8'd1 - pointer_d;
				pes_c      = pointer_d == 8'd0 && n9 >= ppos9 + 9'd3
					&& first_bytes_d == PES_PREFIX;
			end
		end else begin
			new_off_c = ppos9[7:0];
			new_len_c = datalen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			sync_err_q    <= 1'b0;
			tei_q         <= 1'b0;
			pusi_q        <= 1'b0;
			adapt_q       <= 1'b0;
			cc_q          <= '0;
			adapt_len_q   <= '0;
			pointer_q     <= '0;
			first_bytes_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				byte_index_q  <= '0;
				sync_err_q    <= 1'b0;
				tei_q         <= 1'b0;
				pusi_q        <= 1'b0;
				adapt_q       <= 1'b0;
				cc_q          <= '0;
				adapt_len_q   <= '0;
				pointer_q     <= '0;
				first_bytes_q <= '0;
			end else begin
				if (byte_index_q != IDX_MAX)
					byte_index_q <= byte_index_q + 8'd1;
				sync_err_q    <= sync_err_d;
				tei_q         <= tei_d;
				pusi_q        <= pusi_d;
				adapt_q       <= adapt_d;
				cc_q          <= cc_d;
				adapt_len_q   <= adapt_len_d;
				pointer_q     <= pointer_d;
				first_bytes_q <= first_bytes_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict.valid <= 1'b0;
		end else if (load_out) begin
			verdict.valid <= 1'b1;
		end else if (verdict.ready) begin
			verdict.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			verdict.status      <= st;
			verdict.continuity  <= (st == ST_OK) ? cc_d : 4'd0;
			verdict.unit_start  <= (st == ST_OK) ? pusi_d : 1'b0;
			verdict.has_tail    <= has_tail_c;
			verdict.tail_offset <= tail_off_c;
			verdict.tail_length <= tail_len_c;
			verdict.new_offset  <= new_off_c;
			verdict.new_length  <= new_len_c;
			verdict.pes_start   <= pes_c;
		end
	end

`ifndef SYNTH
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.status != ST_OK |-> verdict.continuity == 4'd0
		&& verdict.new_offset == 8'd0 && verdict.new_length == 8'd0
		&& !verdict.has_tail && !verdict.pes_start)
		else $error("error verdict carries nonzero fields");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.status == ST_OK
		|-> {1'b0, verdict.new_offset} + {1'b0, verdict.new_length} == 9'd188)
		else $error("payload span does not reach packet end");
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.status == ST_OK && verdict.has_tail
		|-> verdict.new_offset == verdict.tail_offset + verdict.tail_length)
		else $error("new section does not follow the tail");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> byte_index_q == 8'd0 && !sync_err_q && !pusi_q)
		else $error("header state not cleared after verdict");
`endif

endmodule
`default_nettype wire
